/* design/dual_key_unique_table_defines.svh */
// Assertion macros for the table design.
`ifndef DUAL_KEY_UNIQUE_TABLE_DEFINES_SVH
`define DUAL_KEY_UNIQUE_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DKUT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DKUT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DKUT_ASSERT(label, clk, rst, prop, msg)
`define DKUT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* design/dkut_pkg.sv */
package dkut_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUP_NAME  = 3'd2;
  localparam logic [2:0] ST_DUP_CODE  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam int ENTRY_W = 44 + 64 + 64 + 32 + 24;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [43:0] product_code;
    logic [63:0] name_bytes_lo;
    logic [63:0] name_bytes_mid;
    logic [31:0] name_bytes_hi;
    logic [23:0] price_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] price_out;
  } out_item_t;

  typedef struct packed {
    logic [43:0] code;
    logic [63:0] name_lo;
    logic [63:0] name_mid;
    logic [31:0] name_hi;
    logic [23:0] price;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // capture input item
    logic rd_en;       // read entry at rd_addr
    logic wr_en;       // write entry at wr_addr
    logic wr_item;     // write source: 1 item, 0 last read data
    logic cmp_en;      // compare registered read data
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic code_hit;
    logic name_hit;
  } dp_stat_t;

endpackage

/* design/dkut_ram.sv */
module dkut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/dkut_datapath.sv */
module dkut_datapath #(
  parameter int CAPACITY = 256
) (
  input  logic                        clk,
  input  dkut_pkg::in_item_t          item_in,
  input  dkut_pkg::dp_cmd_t           cmd,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  output dkut_pkg::dp_stat_t          stat,
  output logic [1:0]                  op,
  output logic [23:0]                 rd_price
);
  import dkut_pkg::*;

  in_item_t item;
  entry_t   rd_entry;
  entry_t   wr_entry;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= item_in;
    end
  end

  always_comb begin
    if (cmd.wr_item) begin
      wr_entry = '{item.product_code, item.name_bytes_lo, item.name_bytes_mid,
                   item.name_bytes_hi, item.price_in};
    end else begin
      wr_entry = rd_entry;
    end
  end

  dkut_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_store (
    .clk(clk), .wr_en(cmd.wr_en), .wr_addr(wr_addr), .wr_data(wr_entry),
    .rd_en(cmd.rd_en), .rd_addr(rd_addr), .rd_data(rd_entry)
  );

  // Register compare results so the controller sees a short path.
  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      stat.code_hit <= (rd_entry.code == item.product_code);
      stat.name_hit <= (rd_entry.name_lo == item.name_bytes_lo) &&
                       (rd_entry.name_mid == item.name_bytes_mid) &&
                       (rd_entry.name_hi == item.name_bytes_hi);
      rd_price      <= rd_entry.price;
    end
  end

  assign op = item.opcode;

endmodule

/* design/dkut_ctrl.sv */
module dkut_ctrl #(
  parameter int CAPACITY = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic [23:0]                 price_out,
  output dkut_pkg::dp_cmd_t           cmd,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  dkut_pkg::dp_stat_t          stat,
  input  logic [1:0]                  op,
  input  logic [23:0]                 rd_price
);
  import dkut_pkg::*;
  `include "dual_key_unique_table_defines.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  // scan index of the read issued; pipe flags track read -> cmp -> hit
  logic [CW-1:0] idx, idx_next;
  logic          p1, p1_next, p2, p2_next;
  logic          name_seen, name_seen_next, code_seen, code_seen_next;
  // index of the entry whose hit flags p2 marks
  logic [CW-1:0] hit_idx, hit_idx_next;
  logic [2:0]    status_next;
  logic [23:0]   price_next;
  logic          out_valid_next;
  logic          scan_end;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign rd_addr  = idx[AW-1:0];
  assign wr_addr  = (state == S_SHIFT) ? AW'(idx - CW'(2)) : count[AW-1:0];
  // scan stops once no read or compare is left in flight
  assign scan_end = (idx >= count) && !p1 && !p2;

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    p1_next        = 1'b0;
    p2_next        = p1;
    name_seen_next = name_seen;
    code_seen_next = code_seen;
    hit_idx_next   = hit_idx;
    status_next    = status;
    price_next     = price_out;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISP;
        end
      end
      S_DISP: begin
        idx_next       = '0;
        hit_idx_next   = '0;
        name_seen_next = 1'b0;
        code_seen_next = 1'b0;
        status_next    = ST_OK;
        price_next     = '0;
        if (op == OP_INSERT && count >= CW'(CAPACITY)) begin
          status_next = ST_FULL;
          state_next  = S_DONE;
        end else if (op inside {OP_INSERT, OP_DELETE, OP_LOOKUP}) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (p2) begin
          hit_idx_next = hit_idx + CW'(1);
          if (stat.name_hit) name_seen_next = 1'b1;
          if (stat.code_hit && !code_seen) begin
            code_seen_next = 1'b1;
            if (op == OP_LOOKUP) price_next = rd_price;
          end
        end
        cmd.cmp_en = p1;
        if (idx < count && !(op != OP_INSERT && p2 && stat.code_hit)) begin
          cmd.rd_en = 1'b1;
          idx_next  = idx + CW'(1);
          p1_next   = 1'b1;
        end
        if (op != OP_INSERT && p2 && stat.code_hit && !code_seen) begin
          // first code match: a lookup finishes, a delete moves on to the shift
          p1_next = 1'b0;
          p2_next = 1'b0;
          if (op == OP_LOOKUP) begin
            state_next = S_DONE;
          end else begin
            idx_next   = hit_idx + CW'(1);
            state_next = S_SHIFT;
          end
        end else if (scan_end) begin
          if (op == OP_INSERT) begin
            if (name_seen) status_next = ST_DUP_NAME;
            else if (code_seen) status_next = ST_DUP_CODE;
            else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_item = 1'b1;
              count_next  = count + CW'(1);
            end
          end else begin
            status_next = ST_NOT_FOUND;
            price_next  = '0;
          end
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        // idx counts reads; write entry idx-1 into slot idx-2
        if (p1) begin
          cmd.wr_en = 1'b1;
        end
        if (idx < count) begin
          cmd.rd_en = 1'b1;
          idx_next  = idx + CW'(1);
          p1_next   = 1'b1;
        end else if (!p1) begin
          count_next = count - CW'(1);
          price_next = '0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      p1        <= 1'b0;
      p2        <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      p1        <= p1_next;
      p2        <= p2_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    name_seen <= name_seen_next;
    code_seen <= code_seen_next;
    hit_idx   <= hit_idx_next;
    status    <= status_next;
    price_out <= price_next;
  end

  `DKUT_ASSERT(a_count_cap, clk, rst, count <= CW'(CAPACITY), "entry count over capacity")
  `DKUT_ASSERT(a_no_acc_busy, clk, rst, (state != S_IDLE) |-> !in_ready, "ready while busy")
  `DKUT_ASSERT(a_done_out, clk, rst, (state == S_DONE) |=> out_valid, "result not shown")
  `DKUT_ASSERT(a_count_step, clk, rst,
    (count != $past(count)) |-> ($past(state) == S_SCAN || $past(state) == S_SHIFT),
    "count changed outside scan or shift")

endmodule

/* design/dual_key_unique_table.sv */
// Ordered product table with unique names and codes, one result per item.
// An insert or lookup makes one pass over the N stored entries through the
// single read port of the entry RAM, with a registered read and a compare
// register in the path, and a delete that hits also closes the gap by
// streaming each later entry one slot down with the read and the write of
// neighboring slots overlapped. A full-table insert and opcode 3 skip the
// scan. A result waiting on the output holds off the next input. Stores
// need no clearing after reset.
// Opcode 3 returns ok with zero price.
module dual_key_unique_table #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dkut_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dkut_pkg::out_item_t out_data
);
  import dkut_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [1:0]  op;
  logic [23:0] rd_price;

  dkut_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(out_data.status), .price_out(out_data.price_out),
    .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr), .stat(stat),
    .op(op), .rd_price(rd_price)
  );

  dkut_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .item_in(in_data), .cmd(cmd), .rd_addr(rd_addr),
    .wr_addr(wr_addr), .stat(stat), .op(op), .rd_price(rd_price)
  );

endmodule
